[rtl/core/itbr_pkg.sv]
`default_nettype none

package itbr_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_IDLE  = 2'd3
  } opcode_t;

  localparam logic [2:0] PORT_TONE  = 3'd0;
  localparam logic [2:0] PORT_CLOCK = 3'd2;
  localparam logic [2:0] PORT_SOUND = 3'd4;

  localparam logic [7:0] SOUND_OFF = 8'h00;
  localparam logic [7:0] SOUND_ON  = 8'h01;

  localparam logic [15:0] DIVISOR_RESET = 16'h0001;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] port;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        interrupt_pulse;
    logic        tone_enabled;
    logic [15:0] tone_divisor;
    logic        bad_access;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/core/itbr_ifs.sv]
`default_nettype none

interface itbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] port;
  logic [7:0] write_data;

  modport source (output valid, output opcode, output port, output write_data, input ready);
  modport sink   (input valid, input opcode, input port, input write_data, output ready);
endinterface

interface itbr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        interrupt_pulse;
  logic        tone_enabled;
  logic [15:0] tone_divisor;
  logic        bad_access;

  modport source (output valid, output read_data, output interrupt_pulse,
                  output tone_enabled, output tone_divisor, output bad_access,
                  input ready);
  modport sink   (input valid, input read_data, input interrupt_pulse,
                  input tone_enabled, input tone_divisor, input bad_access,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/interval_timer_bus_registers_core.sv]
// channel  | direction | fields                                            | handshake
// in_bus   | in        | opcode[1:0] port[2:0] write_data[7:0]             | valid/ready
// out_bus  | out       | read_data[7:0] interrupt_pulse tone_enabled       | valid/ready
//          |           | tone_divisor[15:0] bad_access                     |
//
// one word per cycle sustained while out_bus takes results; a taken word is held in the input
// register, then its result in the result register, and out_bus offers it from there
// the input register feeds one pass of register update logic into the result register
// rst_n is synchronous, active low; both stages empty and timer state at reset values
// a stalled result holds and the input register still takes one more word
`default_nettype none

module interval_timer_bus_registers_core
  import itbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itbr_in_if.sink    in_bus,
  itbr_out_if.source out_bus
);

  logic      word_valid;
  in_word_t  word;
  logic      can_load;
  logic      advance;
  out_word_t result;

  assign advance = word_valid && can_load;

  itbr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  itbr_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .word   (word),
    .result (result)
  );

  itbr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

endmodule

`default_nettype wire

[rtl/core/itbr_in_stage.sv]
`default_nettype none

module itbr_in_stage
  import itbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  itbr_in_if.sink   in_bus,
  input  logic      take,
  output logic      word_valid,
  output in_word_t  word
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;

  // free when empty or when the held word moves on this cycle
  assign in_bus.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_bus.valid && in_bus.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      word_r <= '{opcode: in_bus.opcode, port: in_bus.port, write_data: in_bus.write_data};
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

`default_nettype wire

[rtl/core/itbr_regs.sv]
`default_nettype none

module itbr_regs
  import itbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  word,
  output out_word_t result
);

  logic [15:0] tone_latch_r, tone_latch_nxt;
  logic        tone_high_next_r, tone_high_next_nxt;
  logic        tone_valid_r, tone_valid_nxt;
  logic [15:0] applied_div_r, applied_div_nxt;
  logic        tone_on_r, tone_on_nxt;
  logic [15:0] complete_div_r, complete_div_nxt;
  logic [15:0] clock_count_r, clock_count_nxt;
  logic [15:0] clock_start_r, clock_start_nxt;
  logic        clock_high_next_r, clock_high_next_nxt;
  logic        clock_armed_r, clock_armed_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  tempo_r, tempo_nxt;

  logic [7:0]  rd;
  logic        irq;
  logic        bad;
  logic [15:0] tone_full;
  logic [15:0] clock_remaining;

  assign tone_full       = tone_latch_r | {word.write_data, 8'h00};
  assign clock_remaining = clock_start_r - elapsed_r;

  always_comb begin
    tone_latch_nxt      = tone_latch_r;
    tone_high_next_nxt  = tone_high_next_r;
    tone_valid_nxt      = tone_valid_r;
    applied_div_nxt     = applied_div_r;
    tone_on_nxt         = tone_on_r;
    complete_div_nxt    = complete_div_r;
    clock_count_nxt     = clock_count_r;
    clock_start_nxt     = clock_start_r;
    clock_high_next_nxt = clock_high_next_r;
    clock_armed_nxt     = clock_armed_r;
    elapsed_nxt         = elapsed_r;
    tempo_nxt           = tempo_r;
    rd                  = 8'h00;
    irq                 = 1'b0;
    bad                 = 1'b0;

    unique case (word.opcode)
      OP_READ: begin
        if (word.port == PORT_CLOCK) begin
          // one-shot expiry on a read of a count of one
          if (clock_count_r == 16'd1 && clock_armed_r) begin
            clock_armed_nxt = 1'b0;
            irq             = 1'b1;
          end
          if (clock_count_r <= 16'd1) begin
            clock_high_next_nxt = !clock_high_next_r;
          end else if (!clock_high_next_r) begin
            clock_count_nxt     = clock_remaining;
            clock_high_next_nxt = 1'b1;
            rd                  = clock_remaining[7:0];
          end else begin
            clock_high_next_nxt = 1'b0;
            rd                  = clock_count_r[15:8];
          end
        end else if (word.port == PORT_SOUND) begin
          rd        = tempo_r;
          tempo_nxt = tempo_r + 8'd1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_WRITE: begin
        if (word.port == PORT_TONE) begin
          if (!tone_high_next_r) begin
            tone_latch_nxt     = {8'h00, word.write_data};
            tone_high_next_nxt = 1'b1;
          end else begin
            tone_high_next_nxt = 1'b0;
            tone_valid_nxt     = 1'b1;
            // a zero divisor stands for one
            if (tone_full == 16'h0000) begin
              tone_latch_nxt   = DIVISOR_RESET;
              complete_div_nxt = DIVISOR_RESET;
            end else begin
              tone_latch_nxt   = tone_full;
              complete_div_nxt = tone_full;
            end
          end
        end else if (word.port == PORT_CLOCK) begin
          if (!clock_high_next_r) begin
            elapsed_nxt         = 16'h0000;
            clock_armed_nxt     = 1'b1;
            clock_count_nxt     = {8'h00, word.write_data};
            clock_high_next_nxt = 1'b1;
          end else begin
            clock_count_nxt     = clock_count_r | {word.write_data, 8'h00};
            clock_start_nxt     = clock_count_r | {word.write_data, 8'h00};
            clock_high_next_nxt = 1'b0;
          end
        end else if (word.port == PORT_SOUND) begin
          if (word.write_data == SOUND_OFF) begin
            tone_on_nxt = 1'b0;
          end else if (word.write_data == SOUND_ON) begin
            if (tone_valid_r) begin
              applied_div_nxt = complete_div_r;
              tone_on_nxt     = 1'b1;
            end
          end else begin
            bad = 1'b1;
          end
        end
      end
      OP_TICK: begin
        elapsed_nxt = elapsed_r + 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_latch_r      <= 16'h0000;
      tone_high_next_r  <= 1'b0;
      tone_valid_r      <= 1'b0;
      applied_div_r     <= DIVISOR_RESET;
      tone_on_r         <= 1'b0;
      complete_div_r    <= DIVISOR_RESET;
      clock_count_r     <= 16'h0000;
      clock_start_r     <= 16'h0000;
      clock_high_next_r <= 1'b0;
      clock_armed_r     <= 1'b0;
      elapsed_r         <= 16'h0000;
      tempo_r           <= 8'h00;
    end else if (fire) begin
      tone_latch_r      <= tone_latch_nxt;
      tone_high_next_r  <= tone_high_next_nxt;
      tone_valid_r      <= tone_valid_nxt;
      applied_div_r     <= applied_div_nxt;
      tone_on_r         <= tone_on_nxt;
      complete_div_r    <= complete_div_nxt;
      clock_count_r     <= clock_count_nxt;
      clock_start_r     <= clock_start_nxt;
      clock_high_next_r <= clock_high_next_nxt;
      clock_armed_r     <= clock_armed_nxt;
      elapsed_r         <= elapsed_nxt;
      tempo_r           <= tempo_nxt;
    end
  end

  assign result = '{read_data:       rd,
                    interrupt_pulse: irq,
                    tone_enabled:    tone_on_nxt,
                    tone_divisor:    applied_div_nxt,
                    bad_access:      bad};

endmodule

`default_nettype wire

[rtl/core/itbr_out_stage.sv]
`default_nettype none

module itbr_out_stage
  import itbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  out_word_t  result,
  output logic       can_load,
  itbr_out_if.source out_bus
);

  logic      valid_r, valid_nxt;
  out_word_t word_r;

  assign can_load = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= result;
    end
  end

  assign out_bus.valid           = valid_r;
  assign out_bus.read_data       = word_r.read_data;
  assign out_bus.interrupt_pulse = word_r.interrupt_pulse;
  assign out_bus.tone_enabled    = word_r.tone_enabled;
  assign out_bus.tone_divisor    = word_r.tone_divisor;
  assign out_bus.bad_access      = word_r.bad_access;

endmodule

`default_nettype wire

[rtl/core/itbr_checker.sv]
`default_nettype none

module itbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic [7:0]  read_data,
  input logic        interrupt_pulse,
  input logic [15:0] tone_divisor,
  input logic        bad_access
);

  // nothing comes out of reset holding a result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a taken word is followed by a valid result on out_bus, its own or a stalled one ahead of it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("accepted word produced no result");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tone_divisor != 16'h0000))
    else $error("tone divisor is zero");

  // expiry only fires on a clock read of a spent count, which reads zero
  a_irq_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && interrupt_pulse) |-> (read_data == 8'h00 && !bad_access))
    else $error("interrupt with nonzero data or bad access");

endmodule

bind interval_timer_bus_registers_core itbr_checker u_itbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .read_data       (out_bus.read_data),
  .interrupt_pulse (out_bus.interrupt_pulse),
  .tone_divisor    (out_bus.tone_divisor),
  .bad_access      (out_bus.bad_access)
);

`default_nettype wire

[tb/interval_timer_bus_registers_core_tb.sv]
`timescale 1ns / 100ps

module interval_timer_bus_registers_core_tb;
  import itbr_pkg::*;

  // ports with no name in the package
  localparam logic [2:0] PORT_SPARE   = 3'd1;
  localparam logic [2:0] PORT_CONTROL = 3'd3;
  localparam logic [2:0] PORT_TOP     = 3'd7;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  itbr_in_if  in_if ();
  itbr_out_if out_if ();

  interval_timer_bus_registers_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timer register image
  logic [15:0] tone_latch;
  logic        tone_hi_next;
  logic        tone_loaded;
  logic [15:0] tone_full;
  logic [15:0] tone_applied;
  logic        tone_on;
  logic [15:0] cd_count;
  logic [15:0] cd_start;
  logic        cd_hi_next;
  logic        cd_armed;
  logic [15:0] cd_elapsed;
  logic [7:0]  tempo;

  stim_row_t   stim_rows[$];
  out_word_t   expected_results[$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          stall_go;
  bit          sink_hold;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic timer_regs_predict(input in_word_t w, output out_word_t r);
    r = '0;
    case (opcode_t'(w.opcode))
      OP_READ: begin
        if (w.port == PORT_CLOCK) begin
          if (cd_count == 16'd1 && cd_armed) begin
            cd_armed = 1'b0;
            r.interrupt_pulse = 1'b1;
          end
          if (cd_count <= 16'd1) begin
            cd_hi_next = !cd_hi_next;
          end else if (!cd_hi_next) begin
            cd_count = cd_start - cd_elapsed;
            cd_hi_next = 1'b1;
            r.read_data = cd_count[7:0];
          end else begin
            cd_hi_next = 1'b0;
            r.read_data = cd_count[15:8];
          end
        end else if (w.port == PORT_SOUND) begin
          r.read_data = tempo;
          tempo = tempo + 8'd1;
        end else begin
          r.bad_access = 1'b1;
        end
      end
      OP_WRITE: begin
        if (w.port == PORT_TONE) begin
          if (!tone_hi_next) begin
            tone_latch = {8'h00, w.write_data};
            tone_hi_next = 1'b1;
          end else begin
            tone_latch = tone_latch | {w.write_data, 8'h00};
            tone_hi_next = 1'b0;
            if (tone_latch == 16'd0) tone_latch = DIVISOR_RESET;
            tone_full = tone_latch;
            tone_loaded = 1'b1;
          end
        end else if (w.port == PORT_CLOCK) begin
          if (!cd_hi_next) begin
            cd_elapsed = 16'd0;
            cd_armed = 1'b1;
            cd_count = {8'h00, w.write_data};
            cd_hi_next = 1'b1;
          end else begin
            cd_count = cd_count | {w.write_data, 8'h00};
            cd_hi_next = 1'b0;
            cd_start = cd_count;
          end
        end else if (w.port == PORT_SOUND) begin
          if (w.write_data == SOUND_OFF) begin
            tone_on = 1'b0;
          end else if (w.write_data == SOUND_ON) begin
            if (tone_loaded) begin
              tone_applied = tone_full;
              tone_on = 1'b1;
            end
          end else begin
            r.bad_access = 1'b1;
          end
        end
      end
      OP_TICK: begin
        cd_elapsed = cd_elapsed + 16'd1;
      end
      default: begin
      end
    endcase
    r.tone_enabled = tone_on;
    r.tone_divisor = tone_applied;
  endtask

  function automatic out_word_t fixed_result(input logic [7:0] rd, input logic irq,
                                             input logic on, input logic [15:0] div,
                                             input logic bad);
    return {rd, irq, on, div, bad};
  endfunction

  task automatic add_row(input opcode_t op, input logic [2:0] port, input logic [7:0] data,
                         input bit typed, input out_word_t res);
    stim_row_t row;
    row.word   = {op, port, data};
    row.typed  = typed;
    row.result = res;
    stim_rows.push_back(row);
  endtask

  // offer one word and wait for it to be taken; leaves valid high on return
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= w.opcode;
    in_if.port       <= w.port;
    in_if.write_data <= w.write_data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    timer_regs_predict(w, r);
    expected_results.push_back(typed ? typed_res : r);
    words_sent++;
  endtask

  task automatic bus_op(input opcode_t op, input logic [2:0] port, input logic [7:0] data);
    send_word({op, port, data}, 1'b0, '0);
  endtask

  task automatic random_sequence();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  d;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // tone divisor load, all-zero bytes now and then
      repeat (2) begin
        d = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom);
        bus_op(OP_WRITE, PORT_TONE, d);
      end
    end else if (kind < 30) begin
      // countdown load, half the time short so reads reach expiry
      if ($urandom_range(1) == 0) begin
        bus_op(OP_WRITE, PORT_CLOCK, 8'($urandom_range(6)));
        bus_op(OP_WRITE, PORT_CLOCK, 8'h00);
      end else begin
        bus_op(OP_WRITE, PORT_CLOCK, 8'($urandom));
        bus_op(OP_WRITE, PORT_CLOCK, 8'($urandom));
      end
    end else if (kind < 45) begin
      n = $urandom_range(4, 1);
      repeat (n) bus_op(OP_TICK, 3'($urandom), 8'($urandom));
    end else if (kind < 62) begin
      repeat (2) bus_op(OP_READ, PORT_CLOCK, 8'($urandom));
    end else if (kind < 74) begin
      d = ($urandom_range(9) < 8) ? 8'($urandom_range(1)) : 8'($urandom);
      bus_op(OP_WRITE, PORT_SOUND, d);
    end else if (kind < 84) begin
      bus_op(OP_READ, PORT_SOUND, 8'($urandom));
    end else begin
      bus_op(opcode_t'($urandom_range(3)), 3'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = words_sent + count;
    while (words_sent < target) random_sequence();
  endtask

  always @(posedge clk) begin : result_check
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.read_data       = out_if.read_data;
        got.interrupt_pulse = out_if.interrupt_pulse;
        got.tone_enabled    = out_if.tone_enabled;
        got.tone_divisor    = out_if.tone_divisor;
        got.bad_access      = out_if.bad_access;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data ||
              got.interrupt_pulse !== want.interrupt_pulse ||
              got.tone_enabled !== want.tone_enabled ||
              got.tone_divisor !== want.tone_divisor ||
              got.bad_access !== want.bad_access)
            note_failure($sformatf(
              "result %0d mismatch: exp rd %02h irq %0d on %0d div %04h bad %0d, got rd %02h irq %0d on %0d div %04h bad %0d",
              results_seen, want.read_data, want.interrupt_pulse, want.tone_enabled,
              want.tone_divisor, want.bad_access, got.read_data, got.interrupt_pulse,
              got.tone_enabled, got.tone_divisor, got.bad_access));
        end
        results_seen++;
      end
      out_if.ready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    sink_hold = 1'b0;
    wait (stall_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (120) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("interval_timer_bus_registers_core_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned drain;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_IDLE;
    in_if.port       = PORT_TONE;
    in_if.write_data = 8'h00;
    stall_go         = 1'b0;
    words_sent       = 0;
    results_seen     = 0;
    fail_count       = 0;

    tone_latch   = 16'd0;
    tone_hi_next = 1'b0;
    tone_loaded  = 1'b0;
    tone_full    = DIVISOR_RESET;
    tone_applied = DIVISOR_RESET;
    tone_on      = 1'b0;
    cd_count     = 16'd0;
    cd_start     = 16'd0;
    cd_hi_next   = 1'b0;
    cd_armed     = 1'b0;
    cd_elapsed   = 16'd0;
    tempo        = 8'd0;

    // tempo reads and bad ports straight after reset
    add_row(OP_READ, PORT_SOUND, 8'h00, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, DIVISOR_RESET, 1'b0));
    add_row(OP_READ, PORT_SOUND, 8'hff, 1'b1,
            fixed_result(8'h01, 1'b0, 1'b0, DIVISOR_RESET, 1'b0));
    add_row(OP_READ, PORT_TONE, 8'h00, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, DIVISOR_RESET, 1'b1));
    add_row(OP_READ, PORT_TOP, 8'hff, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, DIVISOR_RESET, 1'b1));
    // enable with no divisor loaded, then an illegal sound value
    add_row(OP_WRITE, PORT_SOUND, SOUND_ON, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, DIVISOR_RESET, 1'b0));
    add_row(OP_WRITE, PORT_SOUND, 8'hff, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, DIVISOR_RESET, 1'b1));
    // zero divisor becomes one
    add_row(OP_WRITE, PORT_TONE, 8'h00, 1'b0, '0);
    add_row(OP_WRITE, PORT_TONE, 8'h00, 1'b0, '0);
    add_row(OP_WRITE, PORT_SOUND, SOUND_ON, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b1, 16'h0001, 1'b0));
    add_row(OP_WRITE, PORT_TONE, 8'hff, 1'b0, '0);
    add_row(OP_WRITE, PORT_TONE, 8'hff, 1'b0, '0);
    // enable while on picks up the new divisor
    add_row(OP_WRITE, PORT_SOUND, SOUND_ON, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b1, 16'hffff, 1'b0));
    // half load must not leak into an enable
    add_row(OP_WRITE, PORT_TONE, 8'h34, 1'b0, '0);
    add_row(OP_WRITE, PORT_SOUND, SOUND_ON, 1'b0, '0);
    add_row(OP_WRITE, PORT_SOUND, SOUND_OFF, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, 16'hffff, 1'b0));
    // countdown of 3, two ticks, then reads through expiry
    add_row(OP_WRITE, PORT_CLOCK, 8'h03, 1'b0, '0);
    add_row(OP_WRITE, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_TICK, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_TICK, PORT_TOP, 8'hff, 1'b0, '0);
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_WRITE, PORT_SPARE, 8'haa, 1'b0, '0);
    add_row(OP_WRITE, PORT_CONTROL, 8'hff, 1'b0, '0);
    add_row(OP_IDLE, PORT_CLOCK, 8'hff, 1'b0, '0);
    // pointer back to low byte, then a count that ticks past zero wraps
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_WRITE, PORT_CLOCK, 8'h05, 1'b0, '0);
    add_row(OP_WRITE, PORT_CLOCK, 8'h00, 1'b0, '0);
    repeat (7) add_row(OP_TICK, PORT_TONE, 8'h00, 1'b0, '0);
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);
    add_row(OP_READ, PORT_CLOCK, 8'h00, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 50;
    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].result);

    send_idle_pct = 9;
    recv_idle_pct = 50;
    run_random(520);

    send_idle_pct = 50;
    recv_idle_pct = 9;
    run_random(520);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_go <= 1'b1;
    run_random(260);

    // sender rests until every word has come back
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    run_random(260);

    in_if.valid <= 1'b0;
    drain = 0;
    while (expected_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    if (fail_count == 0) begin
      $display("interval_timer_bus_registers_core_tb: PASS");
    end else begin
      $display("interval_timer_bus_registers_core_tb: FAIL");
    end
    $finish;
  end

endmodule
